[src/mpmc_pkg.sv]
// Shared types and constants for the multi-axis point motion controller.
package mpmc_pkg;

    localparam int CFG_W   = 32;
    localparam int TOL_W   = 16;
    localparam int SPEED_W = 20;
    localparam int DT_W    = 16;
    localparam int STEP_W  = SPEED_W + DT_W;
    localparam int MASK_W  = 8;
    localparam int PADDR_W = 4;

    localparam logic [1:0] REG_SOFT_MIN = 2'd0;
    localparam logic [1:0] REG_SOFT_MAX = 2'd1;
    localparam logic [1:0] REG_TOL      = 2'd2;

    localparam logic signed [CFG_W-1:0] SOFT_MIN_RST = 32'sh8000_0000;
    localparam logic signed [CFG_W-1:0] SOFT_MAX_RST = 32'sh7FFF_FFFF;
    localparam logic [TOL_W-1:0]        TOL_RST      = 16'd1;

    typedef enum logic [3:0] {
        OP_TICK        = 4'd0,
        OP_MOVE_ABS    = 4'd1,
        OP_MOVE_REL    = 4'd2,
        OP_HOME_AXIS   = 4'd3,
        OP_HOME_ALL    = 4'd4,
        OP_STOP_AXIS   = 4'd5,
        OP_STOP_ALL    = 4'd6,
        OP_ESTOP       = 4'd7,
        OP_RESET_ALARM = 4'd8,
        OP_RESET_ESTOP = 4'd9,
        OP_QUERY       = 4'd10,
        OP_INIT        = 4'd11
    } op_t;

    typedef enum logic [2:0] {
        MODE_IDLE   = 3'd0,
        MODE_MOVING = 3'd1,
        MODE_HOMING = 3'd2,
        MODE_DONE   = 3'd3,
        MODE_ALARM  = 3'd4,
        MODE_ESTOP  = 3'd5
    } mode_t;

    typedef struct packed {
        logic cap;
        logic rd;
        logic wr;
        logic fin;
    } mpmc_cmd_t;

endpackage

[src/mpmc_regs.sv]
// APB register file holding soft limits and arrival tolerance.
module mpmc_regs
    import mpmc_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [PADDR_W-1:0]        paddr,
    input  logic [CFG_W-1:0]          pwdata,
    output logic [CFG_W-1:0]          prdata,
    output logic                      pready,
    output logic signed [CFG_W-1:0]   soft_limit_min,
    output logic signed [CFG_W-1:0]   soft_limit_max,
    output logic [TOL_W-1:0]          arrive_tolerance
);

    logic signed [CFG_W-1:0] soft_min_reg;
    logic signed [CFG_W-1:0] soft_max_reg;
    logic [TOL_W-1:0]        tol_reg;
    logic                    wr_en;
    logic [1:0]              reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            soft_min_reg <= SOFT_MIN_RST;
            soft_max_reg <= SOFT_MAX_RST;
            tol_reg      <= TOL_RST;
        end
        else if (wr_en)
        begin
            if (reg_idx == REG_SOFT_MIN)
            begin
                soft_min_reg <= pwdata;
            end
            if (reg_idx == REG_SOFT_MAX)
            begin
                soft_max_reg <= pwdata;
            end
            if (reg_idx == REG_TOL)
            begin
                tol_reg <= pwdata[TOL_W-1:0];
            end
        end
    end

    always_comb
    begin
        prdata = '0;
        if (reg_idx == REG_SOFT_MIN)
        begin
            prdata = soft_min_reg;
        end
        else if (reg_idx == REG_SOFT_MAX)
        begin
            prdata = soft_max_reg;
        end
        else if (reg_idx == REG_TOL)
        begin
            prdata = CFG_W'(tol_reg);
        end
    end

    assign soft_limit_min   = soft_min_reg;
    assign soft_limit_max   = soft_max_reg;
    assign arrive_tolerance = tol_reg;

endmodule

[src/mpmc_ctrl.sv]
// Sequencer that sweeps the axes for each request and hands off the result.
module mpmc_ctrl
    import mpmc_pkg::*;
#(
    parameter int NUM_AXES = 8,
    parameter int AW       = 3
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    output logic          m_tvalid,
    input  logic          m_tready,
    output mpmc_cmd_t     cmd,
    output logic [AW-1:0] idx
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RD,
        ST_WR,
        ST_FIN
    } state_t;

    localparam logic [AW-1:0] LAST_AXIS = AW'(NUM_AXES - 1);

    state_t        state_reg;
    state_t        state_next;
    logic [AW-1:0] cnt_reg;
    logic [AW-1:0] cnt_next;
    logic          valid_reg;
    logic          valid_next;
    logic          out_free;

    assign out_free = !valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = valid_reg;
    assign idx      = cnt_reg;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        valid_next = valid_reg && !m_tready;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.cap    = 1'b1;
                    cnt_next   = '0;
                    state_next = ST_RD;
                end
            end
            ST_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = ST_WR;
            end
            ST_WR:
            begin
                cmd.wr = 1'b1;
                if (cnt_reg == LAST_AXIS)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    cnt_next   = cnt_reg + AW'(1);
                    state_next = ST_RD;
                end
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    cmd.fin    = 1'b1;
                    valid_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            valid_reg <= valid_next;
        end
    end

endmodule

[src/mpmc_dp.sv]
// Axis state storage, per-axis update unit, flags and result register.
module mpmc_dp
    import mpmc_pkg::*;
#(
    parameter int NUM_AXES = 8,
    parameter int POS_BITS = 32,
    parameter int AW       = 3
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  mpmc_cmd_t               cmd,
    input  logic [AW-1:0]           idx,
    input  logic [3:0]              in_op,
    input  logic [2:0]              in_axis,
    input  logic signed [31:0]      in_position,
    input  logic [SPEED_W-1:0]      in_speed,
    input  logic [DT_W-1:0]         in_dt,
    input  logic signed [CFG_W-1:0] soft_limit_min,
    input  logic signed [CFG_W-1:0] soft_limit_max,
    input  logic [TOL_W-1:0]        arrive_tolerance,
    output logic                    ok,
    output logic signed [31:0]      axis_position,
    output logic [2:0]              axis_mode,
    output logic                    alarm_active,
    output logic                    estop_active,
    output logic [MASK_W-1:0]       done_mask
);

    localparam int PW = POS_BITS;
    localparam int TW = ((PW > 32) ? PW : 32) + 2;
    localparam int MW = (PW > STEP_W) ? PW : STEP_W;

    op_t                     op_reg;
    logic [2:0]              axis_reg;
    logic signed [31:0]      pos_reg;
    logic [SPEED_W-1:0]      spd_reg;
    logic [DT_W-1:0]         dt_reg;

    logic [PW-1:0]           cur_reg [NUM_AXES];
    logic [PW-1:0]           tgt_reg [NUM_AXES];
    logic [SPEED_W-1:0]      vel_reg [NUM_AXES];
    mode_t                   mode_reg [NUM_AXES];
    logic                    alarm_reg;
    logic                    estop_reg;
    logic                    bad_reg;
    logic [MASK_W-1:0]       mask_reg;

    logic [PW-1:0]           a_cur_reg;
    logic [PW-1:0]           a_tgt_reg;
    logic [SPEED_W-1:0]      a_vel_reg;
    mode_t                   a_mode_reg;
    logic [STEP_W-1:0]       a_prod_reg;
    logic [PW-1:0]           a_mag_reg;
    logic                    a_neg_reg;

    logic                    out_ok_reg;
    logic signed [31:0]      out_pos_reg;
    mode_t                   out_mode_reg;
    logic                    out_alarm_reg;
    logic                    out_estop_reg;
    logic [MASK_W-1:0]       out_mask_reg;

    logic                    axis_ok;
    logic [AW-1:0]           axis_idx;
    logic [AW-1:0]           rd_idx;
    logic [PW-1:0]           rd_cur;
    logic [PW-1:0]           rd_tgt;
    mode_t                   rd_mode;
    logic [PW:0]             delta;
    logic [PW:0]             delta_neg;

    logic                    hit;
    logic [MW-1:0]           prod_w;
    logic                    prod_ge;
    logic [PW-1:0]           step;
    logic [PW-1:0]           rem;
    logic                    arrived;
    logic [PW-1:0]           moved_cur;
    logic signed [TW-1:0]    tgt_w;
    logic signed [TW-1:0]    lim_lo;
    logic signed [TW-1:0]    lim_hi;
    logic                    in_range;
    logic                    move_bad;
    logic                    move_gate;

    logic [PW-1:0]           n_cur;
    logic [PW-1:0]           n_tgt;
    logic [SPEED_W-1:0]      n_vel;
    mode_t                   n_mode;
    logic                    n_bad;
    logic                    n_done;

    logic                    f_ok;
    logic                    f_alarm;
    logic                    f_estop;
    logic [TW-1:0]           cur_ext;

    assign axis_ok  = (32'(axis_reg) < NUM_AXES);
    assign axis_idx = axis_ok ? AW'(axis_reg) : '0;
    assign rd_idx   = cmd.rd ? idx : axis_idx;
    assign rd_cur   = cur_reg[rd_idx];
    assign rd_tgt   = tgt_reg[rd_idx];
    assign rd_mode  = mode_reg[rd_idx];

    assign delta     = {rd_tgt[PW-1], rd_tgt} - {rd_cur[PW-1], rd_cur};
    assign delta_neg = (~delta) + (PW+1)'(1);

    always_ff @(posedge clk)
    begin
        if (cmd.cap)
        begin
            op_reg   <= op_t'(in_op);
            axis_reg <= in_axis;
            pos_reg  <= in_position;
            spd_reg  <= in_speed;
            dt_reg   <= in_dt;
        end
        if (cmd.rd)
        begin
            a_cur_reg  <= rd_cur;
            a_tgt_reg  <= rd_tgt;
            a_vel_reg  <= vel_reg[rd_idx];
            a_mode_reg <= rd_mode;
            a_neg_reg  <= delta[PW];
            a_mag_reg  <= delta[PW] ? delta_neg[PW-1:0] : delta[PW-1:0];
            a_prod_reg <= STEP_W'(vel_reg[rd_idx]) * STEP_W'(dt_reg);
        end
    end

    // per-axis tick step
    assign prod_w    = MW'(a_prod_reg);
    assign prod_ge   = (prod_w >= MW'(a_mag_reg));
    assign step      = prod_ge ? a_mag_reg : prod_w[PW-1:0];
    assign rem       = prod_ge ? '0 : (a_mag_reg - prod_w[PW-1:0]);
    assign arrived   = (rem < PW'(arrive_tolerance));
    assign moved_cur = a_neg_reg ? (a_cur_reg - step) : (a_cur_reg + step);

    // move target check
    assign tgt_w = (op_reg == OP_MOVE_REL)
                 ? ($signed({{(TW-PW){a_cur_reg[PW-1]}}, a_cur_reg})
                    + $signed({{(TW-32){pos_reg[31]}}, pos_reg}))
                 : $signed({{(TW-32){pos_reg[31]}}, pos_reg});
    assign lim_lo    = $signed({{(TW-CFG_W){soft_limit_min[CFG_W-1]}}, soft_limit_min});
    assign lim_hi    = $signed({{(TW-CFG_W){soft_limit_max[CFG_W-1]}}, soft_limit_max});
    assign in_range  = (tgt_w[TW-1:PW-1] == {(TW-PW+1){tgt_w[PW-1]}});
    assign move_bad  = (tgt_w < lim_lo) || (tgt_w > lim_hi) || !in_range;
    assign move_gate = !estop_reg && !alarm_reg;
    assign hit       = axis_ok && (AW'(axis_reg) == idx);

    always_comb
    begin
        n_cur  = a_cur_reg;
        n_tgt  = a_tgt_reg;
        n_vel  = a_vel_reg;
        n_mode = a_mode_reg;
        n_bad  = 1'b0;
        n_done = 1'b0;
        unique case (op_reg)
            OP_TICK:
            begin
                if (!estop_reg && (a_mode_reg == MODE_MOVING || a_mode_reg == MODE_HOMING))
                begin
                    if (arrived)
                    begin
                        n_cur  = a_tgt_reg;
                        n_mode = MODE_DONE;
                        n_done = 1'b1;
                    end
                    else
                    begin
                        n_cur = moved_cur;
                    end
                end
            end
            OP_MOVE_ABS, OP_MOVE_REL:
            begin
                if (hit && move_gate)
                begin
                    if (move_bad)
                    begin
                        n_mode = MODE_ALARM;
                        n_bad  = 1'b1;
                    end
                    else
                    begin
                        n_tgt  = tgt_w[PW-1:0];
                        n_vel  = spd_reg;
                        n_mode = MODE_MOVING;
                    end
                end
            end
            OP_HOME_AXIS:
            begin
                if (hit && !estop_reg)
                begin
                    n_cur  = '0;
                    n_tgt  = '0;
                    n_mode = MODE_DONE;
                end
            end
            OP_HOME_ALL:
            begin
                if (!estop_reg)
                begin
                    n_cur  = '0;
                    n_tgt  = '0;
                    n_mode = MODE_HOMING;
                end
            end
            OP_STOP_AXIS:
            begin
                if (hit)
                begin
                    n_tgt  = a_cur_reg;
                    n_mode = MODE_IDLE;
                end
            end
            OP_STOP_ALL:
            begin
                n_tgt  = a_cur_reg;
                n_mode = MODE_IDLE;
            end
            OP_ESTOP:
            begin
                n_tgt  = a_cur_reg;
                n_mode = MODE_ESTOP;
            end
            OP_RESET_ALARM:
            begin
                if (!estop_reg && a_mode_reg == MODE_ALARM)
                begin
                    n_mode = MODE_IDLE;
                end
            end
            OP_RESET_ESTOP:
            begin
                n_mode = MODE_IDLE;
            end
            OP_QUERY:
            begin
            end
            OP_INIT:
            begin
                n_cur  = '0;
                n_tgt  = '0;
                n_vel  = '0;
                n_mode = MODE_IDLE;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        f_ok    = 1'b0;
        f_alarm = alarm_reg;
        f_estop = estop_reg;
        unique case (op_reg)
            OP_TICK:
            begin
                f_ok = 1'b1;
            end
            OP_MOVE_ABS, OP_MOVE_REL:
            begin
                f_ok = axis_ok && move_gate && !bad_reg;
                if (bad_reg)
                begin
                    f_alarm = 1'b1;
                end
            end
            OP_HOME_AXIS:
            begin
                f_ok = axis_ok && !estop_reg;
            end
            OP_HOME_ALL:
            begin
                f_ok = !estop_reg;
            end
            OP_STOP_AXIS:
            begin
                f_ok = axis_ok;
            end
            OP_STOP_ALL:
            begin
                f_ok = 1'b1;
            end
            OP_ESTOP:
            begin
                f_ok    = 1'b1;
                f_estop = 1'b1;
            end
            OP_RESET_ALARM:
            begin
                f_ok = !estop_reg;
                if (!estop_reg)
                begin
                    f_alarm = 1'b0;
                end
            end
            OP_RESET_ESTOP, OP_INIT:
            begin
                f_ok    = 1'b1;
                f_alarm = 1'b0;
                f_estop = 1'b0;
            end
            OP_QUERY:
            begin
                f_ok = axis_ok;
            end
            default:
            begin
                f_ok = 1'b0;
            end
        endcase
    end

    assign cur_ext = {{(TW-PW){rd_cur[PW-1]}}, rd_cur};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_AXES; i++)
            begin
                cur_reg[i]  <= '0;
                tgt_reg[i]  <= '0;
                vel_reg[i]  <= '0;
                mode_reg[i] <= MODE_IDLE;
            end
            alarm_reg <= 1'b0;
            estop_reg <= 1'b0;
            bad_reg   <= 1'b0;
            mask_reg  <= '0;
        end
        else
        begin
            if (cmd.cap)
            begin
                bad_reg  <= 1'b0;
                mask_reg <= '0;
            end
            if (cmd.wr)
            begin
                cur_reg[idx]  <= n_cur;
                tgt_reg[idx]  <= n_tgt;
                vel_reg[idx]  <= n_vel;
                mode_reg[idx] <= n_mode;
                if (n_bad)
                begin
                    bad_reg <= 1'b1;
                end
                if (n_done)
                begin
                    mask_reg <= mask_reg | (MASK_W'(1) << idx);
                end
            end
            if (cmd.fin)
            begin
                alarm_reg <= f_alarm;
                estop_reg <= f_estop;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.fin)
        begin
            out_ok_reg    <= f_ok;
            out_pos_reg   <= axis_ok ? $signed(cur_ext[31:0]) : '0;
            out_mode_reg  <= axis_ok ? rd_mode : MODE_IDLE;
            out_alarm_reg <= f_alarm;
            out_estop_reg <= f_estop;
            out_mask_reg  <= mask_reg;
        end
    end

    assign ok            = out_ok_reg;
    assign axis_position = out_pos_reg;
    assign axis_mode     = out_mode_reg;
    assign alarm_active  = out_alarm_reg;
    assign estop_active  = out_estop_reg;
    assign done_mask     = out_mask_reg;

endmodule

[src/multi_axis_point_motion_controller.sv]
// Top level of the multi-axis point motion controller.
//
// Requests enter on the s_ stream: s_tuser carries the command code, s_tdata
// the addressed axis, position or distance, speed and tick interval. One
// response per request leaves on the m_ stream with the accept flag, the
// addressed axis position and mode, both controller flags and the mask of
// axes that arrived on a tick.
// Every request sweeps all axes through one shared update unit, each axis in
// a read and multiply step followed by a compare and write back step.
// One request is in work at a time; s_tready is high only between requests.
// The response sits in an output register; the next request is taken while
// it waits, and a request finishing before m_tready frees that register
// holds in its final step.
// Soft limits and arrival tolerance sit at APB byte addresses 0, 4 and 8.
// The user must write them only while no request is in work; not enforced.
// Reset clears all axis state, both flags and the sequencer and restores the
// register defaults; no clearing pass is needed.
module multi_axis_point_motion_controller
    import mpmc_pkg::*;
#(
    parameter int NUM_AXES = 8,
    parameter int POS_BITS = 32
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    // [2:0] axis, [34:3] position, [54:35] speed, [70:55] dt, [71] zero
    input  logic [71:0]        s_tdata,
    // [3:0] op
    input  logic [3:0]         s_tuser,
    output logic               m_tvalid,
    input  logic               m_tready,
    // [0] ok, [32:1] axis_position, [35:33] axis_mode, [36] alarm_active,
    // [37] estop_active, [45:38] done_mask, [47:46] zero
    output logic [47:0]        m_tdata,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [CFG_W-1:0]   pwdata,
    output logic [CFG_W-1:0]   prdata,
    output logic               pready
);

    localparam int AW = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;

    logic signed [CFG_W-1:0] soft_limit_min;
    logic signed [CFG_W-1:0] soft_limit_max;
    logic [TOL_W-1:0]        arrive_tolerance;
    mpmc_cmd_t               cmd;
    logic [AW-1:0]           idx;
    logic                    ok;
    logic signed [31:0]      axis_position;
    logic [2:0]              axis_mode;
    logic                    alarm_active;
    logic                    estop_active;
    logic [MASK_W-1:0]       done_mask;

    mpmc_regs u_regs (
        .clk              (clk),
        .rst_n            (rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .soft_limit_min   (soft_limit_min),
        .soft_limit_max   (soft_limit_max),
        .arrive_tolerance (arrive_tolerance)
    );

    mpmc_ctrl #(
        .NUM_AXES (NUM_AXES),
        .AW       (AW)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .idx      (idx)
    );

    mpmc_dp #(
        .NUM_AXES (NUM_AXES),
        .POS_BITS (POS_BITS),
        .AW       (AW)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .idx              (idx),
        .in_op            (s_tuser),
        .in_axis          (s_tdata[2:0]),
        .in_position      ($signed(s_tdata[34:3])),
        .in_speed         (s_tdata[54:35]),
        .in_dt            (s_tdata[70:55]),
        .soft_limit_min   (soft_limit_min),
        .soft_limit_max   (soft_limit_max),
        .arrive_tolerance (arrive_tolerance),
        .ok               (ok),
        .axis_position    (axis_position),
        .axis_mode        (axis_mode),
        .alarm_active     (alarm_active),
        .estop_active     (estop_active),
        .done_mask        (done_mask)
    );

    assign m_tdata = {2'b00, done_mask, estop_active, alarm_active, axis_mode,
                      axis_position, ok};

endmodule

[dv/testbench.sv]
// Self-checking testbench for the multi-axis point motion controller.
module testbench;
    import mpmc_pkg::*;

    localparam int     AXES         = 8;
    localparam int     DRAIN_CYCLES = 40;
    localparam int     CYCLE_LIMIT  = 500000;
    localparam int     RANDOM_ITEMS = 160;
    localparam int     PHASES       = 6;
    localparam longint POS_HI       = 64'sd2147483647;
    localparam longint POS_LO       = -POS_HI - 1;

    localparam logic [3:0] OP_UNDEFINED_FIRST = 4'd12;
    localparam logic [3:0] OP_UNDEFINED_LAST  = 4'd15;

    typedef struct packed {
        logic [3:0]         op;
        logic [2:0]         axis;
        logic signed [31:0] position;
        logic [19:0]        speed;
        logic [15:0]        dt;
    } motion_req_t;

    typedef struct packed {
        logic               ok;
        logic [31:0]        pos;
        logic [2:0]         mode;
        logic               alarm;
        logic               estop;
        logic [7:0]         done_mask;
    } motion_rsp_t;

    typedef struct {
        motion_req_t req;
        bit          known;
        motion_rsp_t want;
    } directed_row_t;

    logic               clk;
    logic               rst_n;
    logic               s_tvalid;
    logic               s_tready;
    // [2:0] axis, [34:3] position, [54:35] speed, [70:55] dt, [71] zero
    logic [71:0]        s_tdata;
    // [3:0] op
    logic [3:0]         s_tuser;
    logic               m_tvalid;
    logic               m_tready;
    // [0] ok, [32:1] axis_position, [35:33] axis_mode, [36] alarm_active,
    // [37] estop_active, [45:38] done_mask, [47:46] zero
    logic [47:0]        m_tdata;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [CFG_W-1:0]   pwdata;
    logic [CFG_W-1:0]   prdata;
    logic               pready;

    logic signed [31:0] axis_pos [AXES];
    logic signed [31:0] axis_tgt [AXES];
    logic [19:0]        axis_spd [AXES];
    mode_t              axis_mode [AXES];
    bit                 alarm_on;
    bit                 estop_on;
    longint             lim_lo;
    longint             lim_hi;
    logic [15:0]        tol;

    motion_rsp_t        pending_replies [$];
    directed_row_t      directed_rows [$];
    int                 mismatches;
    int                 src_idle_pct;
    int                 sink_idle_pct;
    int                 stall_left;
    int                 cycle_count;

    multi_axis_point_motion_controller DUT
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    function automatic void wipe_axes();
        int i;
        for (i = 0; i < AXES; i++)
        begin
            axis_pos[i]  = '0;
            axis_tgt[i]  = '0;
            axis_spd[i]  = '0;
            axis_mode[i] = MODE_IDLE;
        end
        alarm_on = 1'b0;
        estop_on = 1'b0;
    endfunction

    function automatic motion_rsp_t advance_controller(motion_req_t r);
        motion_rsp_t rsp;
        int          a;
        int          i;
        longint      goal;
        longint      offset;
        longint      stride;
        longint      rem;
        rsp = '0;
        a = r.axis;
        case (r.op)
            OP_TICK:
            begin
                rsp.ok = 1'b1;
                if (!estop_on)
                begin
                    for (i = 0; i < AXES; i++)
                    begin
                        if (axis_mode[i] == MODE_MOVING || axis_mode[i] == MODE_HOMING)
                        begin
                            offset = longint'(axis_tgt[i]) - longint'(axis_pos[i]);
                            stride = longint'(axis_spd[i]) * longint'(r.dt);
                            if (offset > 0)
                                axis_pos[i] = 32'(longint'(axis_pos[i])
                                              + (stride < offset ? stride : offset));
                            else if (offset < 0)
                                axis_pos[i] = 32'(longint'(axis_pos[i])
                                              - (stride < -offset ? stride : -offset));
                            rem = longint'(axis_tgt[i]) - longint'(axis_pos[i]);
                            if (rem < 0)
                                rem = -rem;
                            if (rem < longint'(tol))
                            begin
                                axis_pos[i]      = axis_tgt[i];
                                axis_mode[i]     = MODE_DONE;
                                rsp.done_mask[i] = 1'b1;
                            end
                        end
                    end
                end
            end
            OP_MOVE_ABS, OP_MOVE_REL:
            begin
                goal = longint'($signed(r.position));
                if (r.op == OP_MOVE_REL)
                    goal = goal + longint'(axis_pos[a]);
                if (!estop_on && !alarm_on)
                begin
                    if (goal < lim_lo || goal > lim_hi || goal < POS_LO || goal > POS_HI)
                    begin
                        axis_mode[a] = MODE_ALARM;
                        alarm_on     = 1'b1;
                    end
                    else
                    begin
                        axis_tgt[a]  = 32'(goal);
                        axis_spd[a]  = r.speed;
                        axis_mode[a] = MODE_MOVING;
                        rsp.ok       = 1'b1;
                    end
                end
            end
            OP_HOME_AXIS:
            begin
                if (!estop_on)
                begin
                    axis_pos[a]  = '0;
                    axis_tgt[a]  = '0;
                    axis_mode[a] = MODE_DONE;
                    rsp.ok       = 1'b1;
                end
            end
            OP_HOME_ALL:
            begin
                if (!estop_on)
                begin
                    for (i = 0; i < AXES; i++)
                    begin
                        axis_pos[i]  = '0;
                        axis_tgt[i]  = '0;
                        axis_mode[i] = MODE_HOMING;
                    end
                    rsp.ok = 1'b1;
                end
            end
            OP_STOP_AXIS:
            begin
                axis_tgt[a]  = axis_pos[a];
                axis_mode[a] = MODE_IDLE;
                rsp.ok       = 1'b1;
            end
            OP_STOP_ALL:
            begin
                for (i = 0; i < AXES; i++)
                begin
                    axis_tgt[i]  = axis_pos[i];
                    axis_mode[i] = MODE_IDLE;
                end
                rsp.ok = 1'b1;
            end
            OP_ESTOP:
            begin
                estop_on = 1'b1;
                for (i = 0; i < AXES; i++)
                begin
                    axis_mode[i] = MODE_ESTOP;
                    axis_tgt[i]  = axis_pos[i];
                end
                rsp.ok = 1'b1;
            end
            OP_RESET_ALARM:
            begin
                if (!estop_on)
                begin
                    alarm_on = 1'b0;
                    for (i = 0; i < AXES; i++)
                    begin
                        if (axis_mode[i] == MODE_ALARM)
                            axis_mode[i] = MODE_IDLE;
                    end
                    rsp.ok = 1'b1;
                end
            end
            OP_RESET_ESTOP:
            begin
                estop_on = 1'b0;
                alarm_on = 1'b0;
                for (i = 0; i < AXES; i++)
                    axis_mode[i] = MODE_IDLE;
                rsp.ok = 1'b1;
            end
            OP_QUERY:
            begin
                rsp.ok = 1'b1;
            end
            OP_INIT:
            begin
                wipe_axes();
                rsp.ok = 1'b1;
            end
            default:
            begin
            end
        endcase
        rsp.pos   = axis_pos[a];
        rsp.mode  = axis_mode[a];
        rsp.alarm = alarm_on;
        rsp.estop = estop_on;
        return rsp;
    endfunction

    function automatic motion_req_t random_request();
        motion_req_t r;
        int          pick;
        r.axis = 3'($urandom);
        if ($urandom_range(0, 9) == 0)
            r.position = $urandom;
        else
            r.position = 32'($urandom_range(0, 100000)) - 32'd50000;
        if ($urandom_range(0, 9) == 0)
            r.speed = 20'($urandom);
        else
            r.speed = 20'($urandom_range(0, 3000));
        if ($urandom_range(0, 9) == 0)
            r.dt = 16'($urandom);
        else
            r.dt = 16'($urandom_range(0, 40));
        pick = $urandom_range(0, 99);
        if (pick < 35)
            r.op = OP_TICK;
        else if (pick < 60)
            r.op = OP_MOVE_ABS;
        else if (pick < 70)
            r.op = OP_MOVE_REL;
        else if (pick < 74)
            r.op = OP_HOME_AXIS;
        else if (pick < 76)
            r.op = OP_HOME_ALL;
        else if (pick < 80)
            r.op = OP_STOP_AXIS;
        else if (pick < 82)
            r.op = OP_STOP_ALL;
        else if (pick < 84)
            r.op = OP_ESTOP;
        else if (pick < 89)
            r.op = OP_RESET_ALARM;
        else if (pick < 95)
            r.op = OP_RESET_ESTOP;
        else if (pick < 98)
            r.op = OP_QUERY;
        else if (pick < 99)
            r.op = OP_INIT;
        else
            r.op = OP_UNDEFINED_FIRST + 4'($urandom_range(0, 3));
        return r;
    endfunction

    function automatic void add_row(logic [3:0] op, logic [2:0] axis, logic [31:0] position,
                                    logic [19:0] speed, logic [15:0] dt,
                                    bit known = 1'b0, motion_rsp_t want = '0);
        directed_row_t row;
        row.req.op       = op;
        row.req.axis     = axis;
        row.req.position = position;
        row.req.speed    = speed;
        row.req.dt       = dt;
        row.known        = known;
        row.want         = want;
        directed_rows.push_back(row);
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %h actual %h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    task automatic send_request(input motion_req_t r, input bit known, input motion_rsp_t want);
        motion_rsp_t model_rsp;
        @(negedge clk);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= r.op;
        s_tdata  <= {1'b0, r.dt, r.speed, r.position, r.axis};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        model_rsp = advance_controller(r);
        pending_replies.push_back(known ? want : model_rsp);
    endtask

    task automatic settle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic apb_write(input logic [1:0] reg_idx, input logic [31:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (reg_idx)
            REG_SOFT_MIN: lim_lo = longint'($signed(value));
            REG_SOFT_MAX: lim_hi = longint'($signed(value));
            REG_TOL:      tol    = value[15:0];
            default:      ;
        endcase
    endtask

    task automatic program_limits(input logic [31:0] lo, input logic [31:0] hi,
                                  input logic [15:0] snap);
        apb_write(REG_SOFT_MIN, lo);
        apb_write(REG_SOFT_MAX, hi);
        apb_write(REG_TOL, {16'd0, snap});
    endtask

    // Receiver: random back-pressure, plus long hold-offs on demand.
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else
                m_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        motion_rsp_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_replies.size() == 0)
            begin
                $display("%0t: response with nothing pending, expected none actual %h",
                         $time, m_tdata);
                mismatches++;
            end
            else
            begin
                want = pending_replies.pop_front();
                check_field("ok", want.ok, m_tdata[0]);
                check_field("axis_position", want.pos, m_tdata[32:1]);
                check_field("axis_mode", want.mode, m_tdata[35:33]);
                check_field("alarm_active", want.alarm, m_tdata[36]);
                check_field("estop_active", want.estop, m_tdata[37]);
                check_field("done_mask", want.done_mask, m_tdata[45:38]);
            end
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        int phase;
        int n;
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        mismatches    = 0;
        stall_left    = 0;
        src_idle_pct  = 31;
        sink_idle_pct = 49;
        wipe_axes();
        lim_lo = longint'(SOFT_MIN_RST);
        lim_hi = longint'(SOFT_MAX_RST);
        tol    = TOL_RST;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        add_row(OP_QUERY, 3'd0, 32'd0, 20'd0, 16'd0, 1'b1,
                motion_rsp_t'{1'b1, 32'd0, MODE_IDLE, 1'b0, 1'b0, 8'h00});
        add_row(OP_MOVE_ABS, 3'd7, 32'h7FFF_FFFF, 20'hF_FFFF, 16'd0, 1'b1,
                motion_rsp_t'{1'b1, 32'd0, MODE_MOVING, 1'b0, 1'b0, 8'h00});
        add_row(OP_TICK, 3'd7, 32'd0, 20'd0, 16'hFFFF, 1'b1,
                motion_rsp_t'{1'b1, 32'h7FFF_FFFF, MODE_DONE, 1'b0, 1'b0, 8'h80});
        add_row(OP_MOVE_ABS, 3'd0, 32'h8000_0000, 20'd1, 16'd0, 1'b1,
                motion_rsp_t'{1'b1, 32'd0, MODE_MOVING, 1'b0, 1'b0, 8'h00});
        add_row(OP_TICK, 3'd0, 32'd0, 20'd0, 16'd1);
        // relative move past the top of the position range
        add_row(OP_MOVE_REL, 3'd7, 32'd1, 20'd5, 16'd0, 1'b1,
                motion_rsp_t'{1'b0, 32'h7FFF_FFFF, MODE_ALARM, 1'b1, 1'b0, 8'h00});
        add_row(OP_MOVE_ABS, 3'd1, 32'd100, 20'd5, 16'd0, 1'b1,
                motion_rsp_t'{1'b0, 32'd0, MODE_IDLE, 1'b1, 1'b0, 8'h00});
        add_row(OP_RESET_ALARM, 3'd7, 32'd0, 20'd0, 16'd0, 1'b1,
                motion_rsp_t'{1'b1, 32'h7FFF_FFFF, MODE_IDLE, 1'b0, 1'b0, 8'h00});
        add_row(OP_HOME_AXIS, 3'd3, 32'd0, 20'd0, 16'd0, 1'b1,
                motion_rsp_t'{1'b1, 32'd0, MODE_DONE, 1'b0, 1'b0, 8'h00});
        add_row(OP_HOME_ALL, 3'd0, 32'd0, 20'd0, 16'd0);
        add_row(OP_TICK, 3'd5, 32'd0, 20'd0, 16'd0, 1'b1,
                motion_rsp_t'{1'b1, 32'd0, MODE_DONE, 1'b0, 1'b0, 8'hFF});
        add_row(OP_MOVE_REL, 3'd2, -32'sd500, 20'd7, 16'd0);
        add_row(OP_MOVE_ABS, 3'd4, 32'd1000, 20'd3, 16'd0);
        add_row(OP_MOVE_ABS, 3'd5, -32'sd1000, 20'hF_FFFF, 16'd0);
        add_row(OP_TICK, 3'd2, 32'd0, 20'd0, 16'd10);
        add_row(OP_STOP_AXIS, 3'd2, 32'd0, 20'd0, 16'd0);
        add_row(OP_STOP_ALL, 3'd4, 32'd0, 20'd0, 16'd0);
        add_row(OP_ESTOP, 3'd6, 32'd0, 20'd0, 16'd0, 1'b1,
                motion_rsp_t'{1'b1, 32'd0, MODE_ESTOP, 1'b0, 1'b1, 8'h00});
        add_row(OP_MOVE_ABS, 3'd0, 32'd5, 20'd9, 16'd0, 1'b1,
                motion_rsp_t'{1'b0, 32'd0, MODE_ESTOP, 1'b0, 1'b1, 8'h00});
        add_row(OP_HOME_AXIS, 3'd1, 32'd0, 20'd0, 16'd0);
        add_row(OP_HOME_ALL, 3'd1, 32'd0, 20'd0, 16'd0);
        add_row(OP_RESET_ALARM, 3'd2, 32'd0, 20'd0, 16'd0);
        add_row(OP_TICK, 3'd4, 32'd0, 20'd0, 16'd100);
        add_row(OP_STOP_AXIS, 3'd3, 32'd0, 20'd0, 16'd0);
        add_row(OP_RESET_ESTOP, 3'd0, 32'd0, 20'd0, 16'd0);
        add_row(OP_UNDEFINED_LAST, 3'd1, 32'hFFFF_FFFF, 20'hF_FFFF, 16'hFFFF);
        add_row(OP_INIT, 3'd5, 32'd0, 20'd0, 16'd0, 1'b1,
                motion_rsp_t'{1'b1, 32'd0, MODE_IDLE, 1'b0, 1'b0, 8'h00});

        foreach (directed_rows[k])
            send_request(directed_rows[k].req, directed_rows[k].known, directed_rows[k].want);
        settle();

        for (phase = 0; phase < PHASES; phase++)
        begin
            case (phase / 2)
                0:
                begin
                    src_idle_pct  = 31;
                    sink_idle_pct = 49;
                end
                1:
                begin
                    src_idle_pct  = 49;
                    sink_idle_pct = 31;
                end
                default:
                begin
                    src_idle_pct  = 0;
                    sink_idle_pct = 0;
                end
            endcase
            case (phase)
                0: program_limits(-32'sd1000000, 32'sd1000000, 16'd1);
                1: program_limits(32'h8000_0000, 32'h7FFF_FFFF, 16'd0);
                2: program_limits(32'd0, 32'd65535, 16'hFFFF);
                // empty window: every move target is out of bounds
                3: program_limits(32'h7FFF_FFFF, 32'h8000_0000, 16'd16);
                4: program_limits(-32'($urandom_range(0, 1 << 20)),
                                  32'($urandom_range(0, 1 << 20)),
                                  16'($urandom_range(0, 300)));
                default: program_limits(32'h8000_0000, 32'h7FFF_FFFF, 16'd1);
            endcase
            for (n = 0; n < RANDOM_ITEMS; n++)
            begin
                if (phase % 4 == 0 && n == 30)
                    stall_left = 250;
                send_request(random_request(), 1'b0, '0);
            end
            settle();
        end

        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

[files.f]
src/mpmc_pkg.sv
src/mpmc_regs.sv
src/mpmc_ctrl.sv
src/mpmc_dp.sv
src/multi_axis_point_motion_controller.sv
dv/testbench.sv
